@@ rtl/core/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg
// shared constants and types for the signed integer to decimal text core
// ----------------------------------------------------------------------------
package itoa_pkg;

	localparam int VALUE_W    = 32;
	localparam int CHAR_W     = 8;
	localparam int DIGIT_W    = 4;
	localparam int MAX_DIGITS = 10;
	localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
	localparam int QUO_W      = 29;

	// x / 10 == (x * 0xcccccccd) >> 35 for every 32-bit unsigned x
	localparam logic [VALUE_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
	localparam int                 DIV10_SHIFT = 35;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

	// one character handed from the sequencer to the output stage
	typedef struct packed {
		logic              valid;
		logic [CHAR_W-1:0] code;
		logic              last;
	} itoa_char_t;

endpackage

@@ rtl/core/signed_int_to_ascii_decimal_core.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_ascii_decimal_core
// signed 32-bit integer to decimal ascii text, one character per item
// ----------------------------------------------------------------------------
//
// channel  dir  tdata                    tlast      meaning
// s_*      in   [31:0] value (signed)    -          integer to convert
// m_*      out  [7:0]  char_code         is_last    '-' or '0'..'9', msd first
//
// steps: the item is taken, then each decimal digit passes through the shared
//   divide-by-ten unit (multiply stage, then remainder), then the characters
//   go out one by one, pausing while the output stalls
// the divide-by-ten unit sets the conversion time, the output port the rest
// s_tready is high only while the sequencer is idle
// output stalls hold the character in the output register and pause emission
// reset clears the sequencer and the output valid; no clearing pass
//
module signed_int_to_ascii_decimal_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [itoa_pkg::VALUE_W-1:0]  s_tdata,   // [31:0] value
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [itoa_pkg::CHAR_W-1:0]   m_tdata,   // [7:0] char_code
	output logic                          m_tlast    // is_last
);
	import itoa_pkg::*;

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIG  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]           state_q;
	logic [VALUE_W-1:0]   mag_q;       // value still to split into digits
	logic                 minus_q;     // minus sign still to be sent
	logic [DIG_IDX_W-1:0] wr_q;        // next digit slot, least significant first
	logic [DIG_IDX_W-1:0] ptr_q;       // next digit to send, most significant first
	logic [DIGIT_W-1:0]   digit_q [MAX_DIGITS];

	logic [QUO_W-1:0]     quotient;
	logic [DIGIT_W-1:0]   remainder;
	logic                 accept;
	logic                 push_ready;
	logic                 send;
	itoa_char_t           push;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// shared divider, loaded with the running magnitude
	itoa_div10 u_div10 (
		.clk       (clk),
		.load      (state_q == ST_MUL),
		.dividend  (mag_q),
		.quotient  (quotient),
		.remainder (remainder)
	);

	// character to send this cycle: sign first, then digits from the top
	always_comb begin
		push.valid = (state_q == ST_EMIT);
		if (minus_q) begin
			push.code = CHAR_MINUS;
			push.last = 1'b0;
		end else begin
			push.code = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit_q[ptr_q]};
			push.last = (ptr_q == '0);
		end
	end

	assign send = push.valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			minus_q <= 1'b0;
			wr_q    <= '0;
			ptr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						minus_q <= s_tdata[VALUE_W-1];
						wr_q    <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIG;
				end
				ST_DIG: begin
					// stop when nothing is left, or the slots are full
					if (quotient == '0 || wr_q == DIG_IDX_W'(MAX_DIGITS - 1)) begin
						ptr_q   <= wr_q;
						state_q <= ST_EMIT;
					end else begin
						wr_q    <= wr_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_EMIT: begin
					if (send) begin
						if (minus_q) begin
							minus_q <= 1'b0;
						end else if (ptr_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							ptr_q <= ptr_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// magnitude and digit buffer, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			// two's complement negate; the most negative value maps to 2^31
			mag_q <= s_tdata[VALUE_W-1] ? (~s_tdata + 1'b1) : s_tdata;
		end else if (state_q == ST_DIG) begin
			mag_q          <= {{(VALUE_W-QUO_W){1'b0}}, quotient};
			digit_q[wr_q]  <= remainder;
		end
	end

	itoa_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

`ifndef SYNTHESIS
	// every character leaving is a minus sign or a decimal digit
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == CHAR_MINUS ||
			(m_tdata >= CHAR_ZERO && m_tdata <= CHAR_NINE)))
		else $error("illegal character on output");

	// a sign is never last, so a minus must be followed by a digit
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata == CHAR_MINUS) |-> !m_tlast)
		else $error("minus sign marked last");

	// the emission pointer stays inside the digit buffer
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (ptr_q < DIG_IDX_W'(MAX_DIGITS)))
		else $error("digit pointer out of range");

	// an accepted item always starts a divide step next
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_MUL))
		else $error("accepted item did not start conversion");
`endif

endmodule

@@ rtl/core/itoa_div10.sv @@
// ----------------------------------------------------------------------------
// itoa_div10
// shared divide-by-ten unit: reciprocal multiply, registered, then remainder
// ----------------------------------------------------------------------------
module itoa_div10 (
	input  logic                           clk,
	input  logic                           load,
	input  logic [itoa_pkg::VALUE_W-1:0]   dividend,
	output logic [itoa_pkg::QUO_W-1:0]     quotient,
	output logic [itoa_pkg::DIGIT_W-1:0]   remainder
);
	import itoa_pkg::*;

	logic [2*VALUE_W-1:0] prod;
	logic [QUO_W-1:0]     quo_s1;
	logic [VALUE_W-1:0]   x_s1;
	logic [VALUE_W-1:0]   times_ten;
	logic [VALUE_W-1:0]   rem_full;

	assign prod = {{VALUE_W{1'b0}}, dividend} * {{VALUE_W{1'b0}}, DIV10_RECIP};

	always_ff @(posedge clk) begin
		if (load) begin
			quo_s1 <= prod[DIV10_SHIFT +: QUO_W];
			x_s1   <= dividend;
		end
	end

	// q*10 as q*8 + q*2
	assign times_ten = {quo_s1, 3'b000} + {2'b00, quo_s1, 1'b0};
	assign rem_full  = x_s1 - times_ten;

	assign quotient  = quo_s1;
	assign remainder = rem_full[DIGIT_W-1:0];

endmodule

@@ rtl/core/itoa_out_reg.sv @@
// ----------------------------------------------------------------------------
// itoa_out_reg
// output register for the character stream, holds an item under stall
// ----------------------------------------------------------------------------
module itoa_out_reg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  itoa_pkg::itoa_char_t        push,
	output logic                        push_ready,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [itoa_pkg::CHAR_W-1:0] m_tdata,
	output logic                        m_tlast
);
	import itoa_pkg::*;

	logic              valid_q;
	logic [CHAR_W-1:0] code_q;
	logic              last_q;

	assign push_ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push_ready) begin
			valid_q <= push.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ready && push.valid) begin
			code_q <= push.code;
			last_q <= push.last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = code_q;
	assign m_tlast  = last_q;

endmodule
